// ----- rtl/core/rpn_pkg.sv -----
package rpn_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 16;
   localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   // Word field widths.
   localparam int CMD_W    = 3;
   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Divider geometry: the dividend is the left operand scaled by 2^FRAC_W.
   localparam int QUOT_W    = DATA_W + FRAC_W;
   localparam int DIV_STEPS = QUOT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Saturation limits.
   localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [QUOT_W-1:0] Q_MIN_MAG = QUOT_W'(1) << (DATA_W - 1);
   localparam logic [QUOT_W-1:0] Q_MAX_MAG = Q_MIN_MAG - QUOT_W'(1);

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4,
      CMD_END  = 3'd5
   } cmd_type;

   // Status codes.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_UNDERFLOW = 2'd1,
      STAT_OVERFLOW  = 2'd2,
      STAT_DIVZERO   = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MULR,
      ST_DIV,
      ST_DIVFIX,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/rpn_req_if.sv -----
interface rpn_req_if import rpn_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [DATA_W-1:0] operand_value;

   modport source (output valid, command, operand_value, input ready);
   modport sink (input valid, command, operand_value, output ready);

endinterface

// ----- rtl/core/rpn_rsp_if.sv -----
interface rpn_rsp_if import rpn_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] top_value;
   logic [COUNT_W-1:0]       stack_count;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, top_value, stack_count, status, input ready);
   modport sink (input valid, top_value, stack_count, status, output ready);

endinterface

// ----- rtl/core/rpn_stack_evaluator.sv -----
// RPN stack evaluator, signed Q16.16, one word at a time through a stack RAM.
// Path from accept to result: push, end, no-op and any error go through ST_EXEC and ST_DONE;
// add and subtract add ST_WRITE, multiply ST_MULR and ST_WRITE, divide the 48 steps of the
// bit-serial divider in ST_DIV, then ST_DIVFIX and ST_WRITE. A new word is taken only once the
// previous result has entered the output register, which ST_DONE waits for; the divider sets the worst case.
// Synchronous reset empties the stack; the stack RAM contents are not cleared.
module rpn_stack_evaluator import rpn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rpn_req_if.sink    req_bus,
   rpn_rsp_if.source  rsp_bus
);

   // Stack RAM and its registered read ports.
   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   logic signed [DATA_W-1:0] rd_top_ff;
   logic signed [DATA_W-1:0] rd_next_ff;

   state_type state_ff, state_in;
   logic [PTR_W-1:0] sp_ff, sp_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic signed [DATA_W-1:0] top_ff, top_in;
   status_type status_ff, status_in;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [DATA_W-1:0] divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic div_neg_ff, div_neg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_top_ff, rsp_top_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic req_accept;
   logic rd_en;
   logic mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [PTR_W-1:0] sp_m1;
   logic [PTR_W-1:0] sp_m2;
   logic signed [DATA_W-1:0] cur_top;
   logic [DATA_W:0] sum_ext;
   logic [DATA_W:0] diff_ext;
   logic signed [2*DATA_W-1:0] rnd;
   logic [DATA_W:0] rem_shift;
   logic [DATA_W:0] rem_sub;
   logic rem_ge;
   logic [DATA_W-1:0] lhs_mag;
   logic [DATA_W-1:0] rhs_mag;

   // Clamp a 33-bit two's complement sum to 32 bits.
   function automatic logic signed [DATA_W-1:0] sat_sum(input logic [DATA_W:0] s);
      logic signed [DATA_W-1:0] r;
      if (s[DATA_W] != s[DATA_W-1]) begin
         r = s[DATA_W] ? MIN_VAL : MAX_VAL;
      end else begin
         r = s[DATA_W-1:0];
      end
      return r;
   endfunction

   assign req_accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rd_en = req_accept;

   assign sp_m1 = sp_ff - PTR_W'(1);
   assign sp_m2 = sp_ff - PTR_W'(2);
   assign cur_top = (sp_ff == '0) ? '0 : rd_top_ff;

   // Add and subtract on sign-extended operands.
   assign sum_ext = {rd_next_ff[DATA_W-1], rd_next_ff} + {rd_top_ff[DATA_W-1], rd_top_ff};
   assign diff_ext = {rd_next_ff[DATA_W-1], rd_next_ff} - {rd_top_ff[DATA_W-1], rd_top_ff};

   // Product rounded half up to Q16.16 (floor after adding one half).
   assign rnd = (prod_ff + (2*DATA_W)'(1 << (FRAC_W - 1))) >>> FRAC_W;

   // One restoring divider step.
   assign rem_shift = {rem_ff, quot_ff[QUOT_W-1]};
   assign rem_sub = rem_shift - {1'b0, divisor_ff};
   assign rem_ge = (rem_shift >= {1'b0, divisor_ff});

   assign lhs_mag = rd_next_ff[DATA_W-1] ? (~rd_next_ff + DATA_W'(1)) : rd_next_ff;
   assign rhs_mag = rd_top_ff[DATA_W-1] ? (~rd_top_ff + DATA_W'(1)) : rd_top_ff;

   // Next state and datapath control.
   always_comb begin
      state_in = state_ff;
      sp_in = sp_ff;
      cmd_in = cmd_ff;
      val_in = val_ff;
      res_in = res_ff;
      top_in = top_ff;
      status_in = status_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      divisor_in = divisor_ff;
      div_cnt_in = div_cnt_ff;
      div_neg_in = div_neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_top_in = rsp_top_ff;
      rsp_count_in = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      mem_we = 1'b0;
      mem_waddr = sp_ff[IDX_W-1:0];
      mem_wdata = val_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in = req_bus.command;
               val_in = req_bus.operand_value;
               status_in = STAT_OK;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_DONE;
            top_in = cur_top;
            case (cmd_ff)
               CMD_PUSH: begin
                  if (sp_ff >= PTR_W'(STACK_DEPTH)) begin
                     status_in = STAT_OVERFLOW;
                  end else begin
                     mem_we = 1'b1;
                     mem_waddr = sp_ff[IDX_W-1:0];
                     mem_wdata = val_ff;
                     sp_in = sp_ff + PTR_W'(1);
                     top_in = val_ff;
                  end
               end
               CMD_ADD, CMD_SUB: begin
                  if (sp_ff < PTR_W'(2)) begin
                     status_in = STAT_UNDERFLOW;
                  end else begin
                     res_in = (cmd_ff == CMD_ADD) ? sat_sum(sum_ext) : sat_sum(diff_ext);
                     state_in = ST_WRITE;
                  end
               end
               CMD_MUL: begin
                  if (sp_ff < PTR_W'(2)) begin
                     status_in = STAT_UNDERFLOW;
                  end else begin
                     prod_in = rd_next_ff * rd_top_ff;
                     state_in = ST_MULR;
                  end
               end
               CMD_DIV: begin
                  if (sp_ff < PTR_W'(2)) begin
                     status_in = STAT_UNDERFLOW;
                  end else if (rd_top_ff == '0) begin
                     status_in = STAT_DIVZERO;
                  end else begin
                     rem_in = '0;
                     quot_in = {lhs_mag, {FRAC_W{1'b0}}};
                     divisor_in = rhs_mag;
                     div_cnt_in = '0;
                     div_neg_in = rd_next_ff[DATA_W-1] ^ rd_top_ff[DATA_W-1];
                     state_in = ST_DIV;
                  end
               end
               CMD_END: begin
                  if (sp_ff == '0) begin
                     status_in = STAT_UNDERFLOW;
                  end else begin
                     sp_in = '0;
                  end
               end
               default: begin
                  top_in = cur_top;
               end
            endcase
         end

         ST_MULR: begin
            // Saturate the rounded product.
            if (rnd > (2*DATA_W)'(MAX_VAL)) begin
               res_in = MAX_VAL;
            end else if (rnd < (2*DATA_W)'(MIN_VAL)) begin
               res_in = MIN_VAL;
            end else begin
               res_in = rnd[DATA_W-1:0];
            end
            state_in = ST_WRITE;
         end

         ST_DIV: begin
            rem_in = rem_ge ? rem_sub[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], rem_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DIVFIX;
            end
         end

         ST_DIVFIX: begin
            // Apply the sign to the truncated quotient and saturate.
            if (div_neg_ff) begin
               res_in = (quot_ff > Q_MIN_MAG) ? MIN_VAL
                                              : (~quot_ff[DATA_W-1:0] + DATA_W'(1));
            end else begin
               res_in = (quot_ff > Q_MAX_MAG) ? MAX_VAL : quot_ff[DATA_W-1:0];
            end
            state_in = ST_WRITE;
         end

         ST_WRITE: begin
            // Replace the left operand with the result and drop the right one.
            mem_we = 1'b1;
            mem_waddr = sp_m2[IDX_W-1:0];
            mem_wdata = res_ff;
            sp_in = sp_m1;
            top_in = res_ff;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_top_in = top_ff;
               rsp_count_in = COUNT_W'(sp_ff);
               rsp_status_in = status_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      val_ff <= val_in;
      res_ff <= res_in;
      top_ff <= top_in;
      status_ff <= status_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      divisor_ff <= divisor_in;
      div_cnt_ff <= div_cnt_in;
      div_neg_ff <= div_neg_in;
      rsp_top_ff <= rsp_top_in;
      rsp_count_ff <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Stack RAM: one write port, two read ports with registered data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_top_ff <= stack_mem[sp_m1[IDX_W-1:0]];
         rd_next_ff <= stack_mem[sp_m2[IDX_W-1:0]];
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.top_value = rsp_top_ff;
   assign rsp_bus.stack_count = rsp_count_ff;
   assign rsp_bus.status = rsp_status_ff;

   // The stack pointer never passes the stack depth.
   assert property (@(posedge clock) disable iff (reset) sp_ff <= PTR_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   // A result write-back always has two operands under it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (sp_ff >= PTR_W'(2)))
      else $error("write-back with fewer than two entries");

   // An accepted word always moves on to execution.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_EXEC))
      else $error("accepted word did not start execution");

   // A divide-by-zero status only ever comes from a divide.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status_ff == STAT_DIVZERO) |-> (cmd_ff == CMD_DIV))
      else $error("divide-by-zero status on a non-divide word");

endmodule
